// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CSFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csfd assertion failed");

// Next-cycle implication
`define CSFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csfd assertion failed");

`endif

// File: rtl/csfd_pkg.sv
// ----------------------------------------------------------------------------
// Current sensor frame decoder package
// Request types, decoded operation type, codes and reset values.
// ----------------------------------------------------------------------------
package csfd_pkg;

  // Input request kinds
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_POLL  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_RESPONSE_ID    = 3'd0;
  localparam logic [2:0] REG_CURRENT_ID     = 3'd1;
  localparam logic [2:0] REG_VOLTAGE1_ID    = 3'd2;
  localparam logic [2:0] REG_VOLTAGE2_ID    = 3'd3;
  localparam logic [2:0] REG_VOLTAGE3_ID    = 3'd4;
  localparam logic [2:0] REG_TEMPERATURE_ID = 3'd5;
  localparam logic [2:0] REG_POWER_ID       = 3'd6;
  localparam logic [2:0] REG_LINK_TIMEOUT   = 3'd7;

  // Register reset values
  localparam logic [10:0] RST_RESPONSE_ID    = 11'd1297;
  localparam logic [10:0] RST_CURRENT_ID     = 11'd1313;
  localparam logic [10:0] RST_VOLTAGE1_ID    = 11'd1314;
  localparam logic [10:0] RST_VOLTAGE2_ID    = 11'd1315;
  localparam logic [10:0] RST_VOLTAGE3_ID    = 11'd1316;
  localparam logic [10:0] RST_TEMPERATURE_ID = 11'd1317;
  localparam logic [10:0] RST_POWER_ID       = 11'd1318;
  localparam logic [15:0] RST_LINK_TIMEOUT   = 16'd1000;

  // Response codes in data byte 0
  localparam logic [7:0] CODE_CONFIG_ACK = 8'hB4;
  localparam logic [7:0] CODE_ACK_FIRST  = 8'hA0;
  localparam logic [7:0] CODE_ACK_LAST   = 8'hA5;
  localparam logic [7:0] CODE_STORE_ACK  = 8'hB2;
  localparam logic [7:0] CODE_START_ACK  = 8'hB0;
  localparam logic [7:0] CODE_SYS_ERR    = 8'h81;
  localparam logic [7:0] CODE_MEAS_ERR   = 8'h80;

  // Outgoing request codes
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_SYS  = 2'd1;
  localparam logic [1:0] REQ_MEAS = 2'd2;

  // Fault flag positions
  localparam int unsigned FLT_CAN     = 0;
  localparam int unsigned FLT_POWER   = 1;
  localparam int unsigned FLT_CURRENT = 2;
  localparam int unsigned FLT_VREF    = 3;
  localparam int unsigned FLT_TEMP    = 4;
  localparam int unsigned FLT_U1OC    = 5;
  localparam int unsigned FLT_U2OC    = 6;
  localparam int unsigned FLT_U3OC    = 7;
  localparam int unsigned FLT_IOC     = 8;
  localparam int unsigned FLT_NTCL    = 9;
  localparam int unsigned FLT_NTCH    = 10;
  localparam int unsigned FLT_ADC     = 11;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [10:0] frame_id;
    logic [7:0]  payload_byte0;
    logic [7:0]  payload_byte1;
    logic [7:0]  payload_byte2;
    logic [7:0]  payload_byte3;
    logic [7:0]  payload_byte4;
    logic [7:0]  payload_byte5;
  } item_t;

  typedef struct packed {
    logic signed [31:0] current_now;
    logic signed [31:0] voltage_now;
    logic signed [31:0] temperature_now;
    logic signed [31:0] power_now;
    logic               ack_seen;
    logic [11:0]        fault_bits;
    logic               link_good;
    logic [1:0]         send_request;
    logic               unknown_frame;
  } result_t;

  // Configuration write as seen by the internal parts
  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  // Decoded operation handed from front to back
  typedef enum logic [3:0] {
    OP_NOP,
    OP_RESP,
    OP_CURRENT,
    OP_VOLTAGE,
    OP_TEMP,
    OP_POWER,
    OP_IGNORE,
    OP_UNKNOWN,
    OP_TICK,
    OP_POLL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        ack;
    logic        sys_err;
    logic        meas_err;
    logic [31:0] word;
  } dec_t;

  // Queue status towards front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/csfd_front.sv
// ----------------------------------------------------------------------------
// Frame decoder front end
// Holds the ID registers, accepts requests and classifies them for the queue.
// ----------------------------------------------------------------------------
module csfd_front import csfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg_wr,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_data,
  input  q_stat_t q_stat,
  output logic    push,
  output dec_t    push_data
);

  logic [10:0] response_id;
  logic [10:0] current_id;
  logic [10:0] voltage1_id;
  logic [10:0] voltage2_id;
  logic [10:0] voltage3_id;
  logic [10:0] temperature_id;
  logic [10:0] power_id;
  logic        is_ack;
  logic        is_resp;

  // Write the ID registers
  always_ff @(posedge clk) begin
    if (rst) begin
      response_id    <= RST_RESPONSE_ID;
      current_id     <= RST_CURRENT_ID;
      voltage1_id    <= RST_VOLTAGE1_ID;
      voltage2_id    <= RST_VOLTAGE2_ID;
      voltage3_id    <= RST_VOLTAGE3_ID;
      temperature_id <= RST_TEMPERATURE_ID;
      power_id       <= RST_POWER_ID;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_RESPONSE_ID:    response_id    <= cfg_wr.data[10:0];
        REG_CURRENT_ID:     current_id     <= cfg_wr.data[10:0];
        REG_VOLTAGE1_ID:    voltage1_id    <= cfg_wr.data[10:0];
        REG_VOLTAGE2_ID:    voltage2_id    <= cfg_wr.data[10:0];
        REG_VOLTAGE3_ID:    voltage3_id    <= cfg_wr.data[10:0];
        REG_TEMPERATURE_ID: temperature_id <= cfg_wr.data[10:0];
        REG_POWER_ID:       power_id       <= cfg_wr.data[10:0];
        default: ;
      endcase
    end
  end

  // Accept whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Detect acknowledge codes of a response frame
  always_comb begin
    is_ack = 1'b0;
    if (in_data.payload_byte0 == CODE_CONFIG_ACK &&
        (in_data.payload_byte1 == 8'd0 || in_data.payload_byte1 == 8'd1) &&
        in_data.payload_byte2 == 8'd1) begin
      is_ack = 1'b1;
    end
    if (in_data.payload_byte0 inside {[CODE_ACK_FIRST:CODE_ACK_LAST],
                                      CODE_START_ACK, CODE_STORE_ACK}) begin
      is_ack = 1'b1;
    end
  end

  assign is_resp = (in_data.frame_id == response_id);

  // Classify the request; first matching ID wins
  always_comb begin
    push_data.ack      = 1'b0;
    push_data.sys_err  = 1'b0;
    push_data.meas_err = 1'b0;
    push_data.word     = {in_data.payload_byte2, in_data.payload_byte3,
                          in_data.payload_byte4, in_data.payload_byte5};
    case (in_data.cmd)
      CMD_FRAME: begin
        if (is_resp) begin
          push_data.op       = OP_RESP;
          push_data.ack      = is_ack;
          push_data.sys_err  = (in_data.payload_byte0 == CODE_SYS_ERR) &&
                               (in_data.payload_byte1 == 8'd0);
          push_data.meas_err = (in_data.payload_byte0 == CODE_MEAS_ERR) &&
                               (in_data.payload_byte1 == 8'd0);
        end else if (in_data.frame_id == current_id) begin
          push_data.op = OP_CURRENT;
        end else if (in_data.frame_id == voltage1_id) begin
          push_data.op = OP_VOLTAGE;
        end else if (in_data.frame_id == voltage2_id ||
                     in_data.frame_id == voltage3_id) begin
          push_data.op = OP_IGNORE;
        end else if (in_data.frame_id == temperature_id) begin
          push_data.op = OP_TEMP;
        end else if (in_data.frame_id == power_id) begin
          push_data.op = OP_POWER;
        end else begin
          push_data.op = OP_UNKNOWN;
        end
      end
      CMD_TICK: push_data.op = OP_TICK;
      CMD_POLL: push_data.op = OP_POLL;
      default:  push_data.op = OP_NOP;
    endcase
  end

endmodule

// File: rtl/csfd_queue.sv
// ----------------------------------------------------------------------------
// Decoded request queue
// Small first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module csfd_queue import csfd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  dec_t    push_data,
  input  logic    pop,
  output dec_t    head,
  output q_stat_t q_stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  dec_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_stat.full  = (count == FULL_COUNT);
  assign q_stat.empty = (count == '0);
  assign head         = mem[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/csfd_back.sv
// ----------------------------------------------------------------------------
// Frame decoder back end
// Applies decoded requests to the readings, fault flags and link state, and
// drives the registered result.
// ----------------------------------------------------------------------------
module csfd_back import csfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg_wr,
  input  q_stat_t q_stat,
  input  dec_t    head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic [15:0]        link_timeout_ms;
  logic signed [31:0] current_reg;
  logic signed [31:0] voltage_reg;
  logic signed [31:0] temperature_reg;
  logic signed [31:0] power_reg;
  logic [11:0]        fault_reg;
  logic               link_ok_reg;
  logic [15:0]        idle_ms_counter;

  logic signed [31:0] current_next;
  logic signed [31:0] voltage_next;
  logic signed [31:0] temperature_next;
  logic signed [31:0] power_next;
  logic [11:0]        fault_next;
  logic               link_ok_next;
  logic [15:0]        idle_next;
  logic               ack;
  logic               unknown;
  logic [1:0]         req;
  logic [7:0]         lo;
  logic [7:0]         hi;

  assign lo  = head.word[31:24];
  assign hi  = head.word[23:16];
  assign pop = !q_stat.empty && (!out_valid || out_ready);

  // Hold the link timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_timeout_ms <= RST_LINK_TIMEOUT;
    end else if (cfg_wr.valid && cfg_wr.index == REG_LINK_TIMEOUT) begin
      link_timeout_ms <= cfg_wr.data;
    end
  end

  // Work out the state after the head request
  always_comb begin
    current_next     = current_reg;
    voltage_next     = voltage_reg;
    temperature_next = temperature_reg;
    power_next       = power_reg;
    fault_next       = fault_reg;
    link_ok_next     = link_ok_reg;
    idle_next        = idle_ms_counter;
    ack              = 1'b0;
    unknown          = 1'b0;
    req              = REQ_NONE;
    case (head.op)
      OP_RESP: begin
        idle_next = '0;
        ack       = head.ack;
        if (head.sys_err) begin
          fault_next[FLT_CAN]     = lo[3] || !link_ok_reg;
          fault_next[FLT_POWER]   = lo[6];
          fault_next[FLT_CURRENT] = 1'b0;
          fault_next[FLT_VREF]    = 1'b0;
          fault_next[FLT_TEMP]    = lo[4] || lo[5];
          req                     = REQ_MEAS;
        end
        if (head.meas_err) begin
          fault_next[FLT_ADC]     = |lo[4:0];
          fault_next[FLT_VREF]    = fault_reg[FLT_VREF] || lo[5];
          fault_next[FLT_CURRENT] = fault_reg[FLT_CURRENT] || lo[6];
          fault_next[FLT_IOC]     = hi[0];
          fault_next[FLT_U1OC]    = hi[1];
          fault_next[FLT_U2OC]    = hi[2];
          fault_next[FLT_U3OC]    = hi[3];
          fault_next[FLT_NTCH]    = hi[4];
          fault_next[FLT_NTCL]    = hi[5];
        end
      end
      OP_CURRENT: begin
        idle_next    = '0;
        current_next = signed'(head.word);
      end
      OP_VOLTAGE: begin
        idle_next    = '0;
        voltage_next = signed'(head.word);
      end
      OP_TEMP: begin
        idle_next        = '0;
        temperature_next = signed'(head.word);
      end
      OP_POWER: begin
        idle_next  = '0;
        power_next = signed'(head.word);
      end
      OP_IGNORE: idle_next = '0;
      OP_UNKNOWN: begin
        idle_next = '0;
        unknown   = 1'b1;
      end
      OP_TICK: begin
        // Saturate at full scale
        if (idle_ms_counter != '1) begin
          idle_next = idle_ms_counter + 1'b1;
        end
      end
      OP_POLL: begin
        link_ok_next = (idle_ms_counter <= link_timeout_ms);
        req          = REQ_SYS;
      end
      default: ;
    endcase
  end

  // Update state on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      current_reg     <= '0;
      voltage_reg     <= '0;
      temperature_reg <= '0;
      power_reg       <= '0;
      fault_reg       <= '0;
      link_ok_reg     <= 1'b0;
      idle_ms_counter <= '0;
    end else if (pop) begin
      current_reg     <= current_next;
      voltage_reg     <= voltage_next;
      temperature_reg <= temperature_next;
      power_reg       <= power_next;
      fault_reg       <= fault_next;
      link_ok_reg     <= link_ok_next;
      idle_ms_counter <= idle_next;
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.current_now     <= current_next;
      out_data.voltage_now     <= voltage_next;
      out_data.temperature_now <= temperature_next;
      out_data.power_now       <= power_next;
      out_data.ack_seen        <= ack;
      out_data.fault_bits      <= fault_next;
      out_data.link_good       <= link_ok_next;
      out_data.send_request    <= req;
      out_data.unknown_frame   <= unknown;
    end
  end

endmodule

// File: rtl/current_sensor_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// Current sensor frame decoder
// Decodes shunt sensor CAN frames, millisecond ticks and fault-check polls.
//
//   channel   direction  signals
//   in        request    in_valid / in_ready / in_data (item_t)
//   out       result     out_valid / out_ready / out_data (result_t)
//   cfg       write      cfg_valid / cfg_ready / cfg_index / cfg_data
//
// One request is taken per cycle while in_ready is high and gives one result.
// The accepting edge classifies the request into the queue; when the back end
// pops it, it applies the request and registers the result. rst is
// synchronous and restores the ID registers, the readings, the faults and
// the idle counter. A stalled output fills the queue of QUEUE_DEPTH entries,
// then in_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module current_sensor_frame_decoder_top import csfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_wr_t cfg_wr;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  dec_t    push_data;
  dec_t    head;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  csfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  csfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  csfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/csfd_checker.sv
// ----------------------------------------------------------------------------
// Frame decoder port checker
// Watches the top level ports over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csfd_checker import csfd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input result_t     out_data,
  input logic        cfg_ready
);

  // Hold a stalled result
  `CSFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CSFD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))

  // An unknown frame neither acknowledges nor requests
  `CSFD_ASSERT_NOW(a_unknown_quiet, out_valid && out_data.unknown_frame,
                   !out_data.ack_seen && out_data.send_request == REQ_NONE)

  // Acknowledges come only from response frames, which never ask for system errors
  `CSFD_ASSERT_NOW(a_ack_no_poll, out_valid && out_data.ack_seen,
                   out_data.send_request != REQ_SYS)

  // Register writes are never held off
  `CSFD_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind current_sensor_frame_decoder_top csfd_checker u_csfd_checker (.*);
